[design/pdwp_pkg.sv]
`timescale 1ns / 1ps

package pdwp_pkg;

  localparam int DUR_W      = 20;
  localparam int HALF_W     = 15;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [HALF_W-1:0] CHUNK_MAX = 15'd32767;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_FINISH  = 1'b1;

  localparam logic [1:0] REG_CELL_MODE  = 2'd0;
  localparam logic [1:0] REG_PERIOD     = 2'd1;
  localparam logic [1:0] REG_IDLE_LEVEL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic             cell_mode;
    logic [DUR_W-1:0] period;
    logic             idle_level;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [DUR_W-1:0] duration;
    logic             level;
    logic [DUR_W-1:0] duty;
  } in_word_t;

  typedef struct packed {
    logic [HALF_W-1:0] first_duration;
    logic              first_level;
    logic [HALF_W-1:0] second_duration;
    logic              second_level;
    logic              end_word;
    logic              bad_duty;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;
    logic run_done;
    logic need_slot;
    logic pend_valid;
    logic slot_free;
  } dp_stat_t;

endpackage

[design/pdwp_if.sv]
`timescale 1ns / 1ps

interface pdwp_in_if;
  import pdwp_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [DUR_W-1:0] duration;
  logic             level;
  logic [DUR_W-1:0] duty;

  modport source (output valid, output operation, output duration, output level,
                  output duty, input ready);
  modport sink (input valid, input operation, input duration, input level,
                input duty, output ready);
endinterface

interface pdwp_out_if;
  import pdwp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] first_duration;
  logic              first_level;
  logic [HALF_W-1:0] second_duration;
  logic              second_level;
  logic              end_word;
  logic              bad_duty;
  logic              last;

  modport source (output valid, output first_duration, output first_level,
                  output second_duration, output second_level, output end_word,
                  output bad_duty, output last, input ready);
  modport sink (input valid, input first_duration, input first_level,
                input second_duration, input second_level, input end_word,
                input bad_duty, input last, output ready);
endinterface

[design/pulse_duration_word_packer_core.sv]
`timescale 1ns / 1ps
// every word passes through the pending register and then the output register; a finish
// or bad-duty word goes straight to the flush, an element first runs its chunk steps
// a new input word is taken only in idle, after the last one is flushed; the run loop
// takes one step per chunk half and one for the switch to the low part of a cell
// a full output register stalls the flush, and the run loop when a finished word waits for it, until the word is taken
// reset: synchronous active-low rst_n clears configuration, held half and control state

module pulse_duration_word_packer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  pdwp_in_if.sink                         in_chan,
  pdwp_out_if.source                      out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pdwp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pdwp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pdwp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pdwp_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word;
  out_word_t out_word;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  assign in_word.operation = in_chan.operation;
  assign in_word.duration  = in_chan.duration;
  assign in_word.level     = in_chan.level;
  assign in_word.duty      = in_chan.duty;
  assign in_chan.ready     = in_ready;

  assign out_chan.valid           = out_valid;
  assign out_chan.first_duration  = out_word.first_duration;
  assign out_chan.first_level     = out_word.first_level;
  assign out_chan.second_duration = out_word.second_duration;
  assign out_chan.second_level    = out_word.second_level;
  assign out_chan.end_word        = out_word.end_word;
  assign out_chan.bad_duty        = out_word.bad_duty;
  assign out_chan.last            = out_word.last;

  pdwp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pdwp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdwp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

[design/pdwp_cfg.sv]
`timescale 1ns / 1ps

module pdwp_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pdwp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pdwp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pdwp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output pdwp_pkg::cfg_t                      cfg
);
  import pdwp_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CELL_MODE:  cfg_nxt.cell_mode  = cfg_pwdata[0];
        REG_PERIOD:     cfg_nxt.period     = cfg_pwdata[DUR_W-1:0];
        REG_IDLE_LEVEL: cfg_nxt.idle_level = cfg_pwdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CELL_MODE:  cfg_prdata = CFG_DATA_W'(cfg_r.cell_mode);
      REG_PERIOD:     cfg_prdata = CFG_DATA_W'(cfg_r.period);
      REG_IDLE_LEVEL: cfg_prdata = CFG_DATA_W'(cfg_r.idle_level);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/pdwp_ctrl.sv]
`timescale 1ns / 1ps

module pdwp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdwp_pkg::dp_stat_t   stat,
  output pdwp_pkg::ctrl_cmd_t  cmd
);
  import pdwp_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.direct ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.run_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid || stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step     = !stat.run_done && (!stat.need_slot || stat.slot_free);
        cmd.out_load = !stat.run_done && stat.need_slot && stat.slot_free;
      end
      ST_FLUSH: begin
        cmd.out_load = stat.pend_valid && stat.slot_free;
        cmd.out_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/pdwp_dp.sv]
`timescale 1ns / 1ps

module pdwp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdwp_pkg::cfg_t       cfg,
  input  pdwp_pkg::in_word_t   in_word,
  input  pdwp_pkg::ctrl_cmd_t  cmd,
  output pdwp_pkg::dp_stat_t   stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output pdwp_pkg::out_word_t  out_word
);
  import pdwp_pkg::*;

  logic [DUR_W-1:0]  rem_r, rem_nxt;
  logic [DUR_W-1:0]  rem2_r, rem2_nxt;
  logic              lvl_r, lvl_nxt;
  logic [HALF_W-1:0] held_dur_r, held_dur_nxt;
  logic              held_lvl_r, held_lvl_nxt;
  logic              held_valid_r, held_valid_nxt;
  out_word_t         pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HALF_W-1:0] chunk;
  logic              bad_cell;

  assign bad_cell = cfg.cell_mode && (in_word.duty > cfg.period);
  assign chunk    = (rem_r > DUR_W'(CHUNK_MAX)) ? CHUNK_MAX : rem_r[HALF_W-1:0];

  assign stat.direct     = (in_word.operation == OP_FINISH) || bad_cell;
  assign stat.run_done   = (rem_r == '0) && (rem2_r == '0);
  assign stat.need_slot  = (rem_r != '0) && held_valid_r && pend_valid_r;
  assign stat.pend_valid = pend_valid_r;
  assign stat.slot_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    rem_nxt        = rem_r;
    rem2_nxt       = rem2_r;
    lvl_nxt        = lvl_r;
    held_dur_nxt   = held_dur_r;
    held_lvl_nxt   = held_lvl_r;
    held_valid_nxt = held_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    if (cmd.load) begin
      if (in_word.operation == OP_FINISH) begin
        // close the open word, or send an all-idle end marker
        pend_nxt                 = '0;
        pend_nxt.first_duration  = held_valid_r ? held_dur_r : '0;
        pend_nxt.first_level     = held_valid_r ? held_lvl_r : cfg.idle_level;
        pend_nxt.second_level    = cfg.idle_level;
        pend_nxt.end_word        = 1'b1;
        pend_valid_nxt           = 1'b1;
        held_dur_nxt             = '0;
        held_lvl_nxt             = 1'b0;
        held_valid_nxt           = 1'b0;
        rem_nxt                  = '0;
        rem2_nxt                 = '0;
      end else if (cfg.cell_mode) begin
        if (bad_cell) begin
          pend_nxt          = '0;
          pend_nxt.bad_duty = 1'b1;
          pend_valid_nxt    = 1'b1;
          rem_nxt           = '0;
          rem2_nxt          = '0;
        end else begin
          rem_nxt  = in_word.duty;
          lvl_nxt  = 1'b1;
          rem2_nxt = cfg.period - in_word.duty;
        end
      end else begin
        rem_nxt  = in_word.duration;
        lvl_nxt  = in_word.level;
        rem2_nxt = '0;
      end
    end

    if (cmd.step) begin
      if (rem_r == '0) begin
        // move on to the low part of the cell
        rem_nxt  = rem2_r;
        rem2_nxt = '0;
        lvl_nxt  = 1'b0;
      end else begin
        rem_nxt = rem_r - DUR_W'(chunk);
        if (held_valid_r) begin
          pend_nxt                 = '0;
          pend_nxt.first_duration  = held_dur_r;
          pend_nxt.first_level     = held_lvl_r;
          pend_nxt.second_duration = chunk;
          pend_nxt.second_level    = lvl_r;
          pend_valid_nxt           = 1'b1;
          held_dur_nxt             = '0;
          held_lvl_nxt             = 1'b0;
          held_valid_nxt           = 1'b0;
        end else begin
          held_dur_nxt   = chunk;
          held_lvl_nxt   = lvl_r;
          held_valid_nxt = 1'b1;
        end
      end
    end

    if (cmd.out_load) begin
      out_nxt       = pend_r;
      out_nxt.last  = cmd.out_last;
      out_valid_nxt = 1'b1;
      if (cmd.out_last) begin
        pend_valid_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_dur_r   <= '0;
      held_lvl_r   <= 1'b0;
      held_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_dur_r   <= held_dur_nxt;
      held_lvl_r   <= held_lvl_nxt;
      held_valid_r <= held_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    rem2_r <= rem2_nxt;
    lvl_r  <= lvl_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule
